// ===== hw/rtl/pidc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller package
// Register indexes, field widths and the saturation helper shared by the
// controller datapath.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPropGain  = 3'd0,
    CfgIntegGain = 3'd1,
    CfgDerivGain = 3'd2,
    CfgTermLimit = 3'd3,
    CfgIntegHigh = 3'd4,
    CfgIntegLow  = 3'd5,
    CfgOutHigh   = 3'd6,
    CfgOutLow    = 3'd7
  } cfg_idx_e;

  // Saturate a wide signed value to [lo, hi]; the upper test wins when the
  // limits are crossed. Limits always lie in 16-bit range.
  function automatic logic signed [DataW-1:0] clamp_s16(
    input logic signed [33:0]    v,
    input logic signed [DataW:0] hi,
    input logic signed [DataW:0] lo
  );
    logic signed [DataW-1:0] r;
    if (v > hi) begin
      r = hi[DataW-1:0];
    end else if (v < lo) begin
      r = lo[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pid_controller_clamped_terms_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller with clamped terms
// Speed loop controller: Q8.8 gains, shared P/D term limit, clamped and
// stored integral (anti-windup), clamped command output.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_ready_o   setpoint_i, measured_i
//  out      source     out_valid_o / out_ready_i command_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  One sample per cycle sustained unless the command channel stalls; samples
//  pass the error, products, integral/derivative product and sum stages.
//  The integral loop closes on the stored sum plus the scaled product.
//  Each stage holds only while the stage after it is full and stalled, so
//  bubbles collapse and input keeps flowing while a result waits.
//  Reset clears gains to zero, limits to full range and the loop state.
// ----------------------------------------------------------------------------
module pid_controller_clamped_terms_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic signed [pidc_pkg::DataW-1:0]   setpoint_i,
  input  wire logic signed [pidc_pkg::DataW-1:0]   measured_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [pidc_pkg::DataW-1:0]   command_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [pidc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [pidc_pkg::DataW-1:0]          cfg_data_i
);

  // configuration
  logic signed [15:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic        [14:0] term_limit_q;
  logic signed [15:0] integ_high_q, integ_low_q, out_high_q, out_low_q;

  // loop state
  logic signed [16:0] prev_err_q;
  logic signed [15:0] integ_q;

  // pipeline control
  logic v0_q, v1_q, v2_q, v3_q;
  logic ld0, ld1, ld2, ld3;
  logic in_xfer;

  // stage 0: error and error change
  logic signed [16:0] err_d, err_q;
  logic signed [17:0] diff_d, diff_q;
  // stage 1: products
  logic signed [32:0] p_prod_d, p_prod_q, i_prod_d, i_prod_q;
  logic signed [24:0] diff_ext, d100_d, d100_q;
  // stage 2: P and I terms, derivative product
  logic signed [15:0] p_term_d, p_term_q, i_term_d, i_term_q;
  logic signed [25:0] i_sum;
  logic signed [40:0] d_prod_d, d_prod_q;
  // stage 3: sum and command
  logic signed [15:0] d_term;
  logic signed [17:0] sum;
  logic signed [15:0] cmd_d, command_q;

  logic signed [16:0] lim_pos, lim_neg;

  assign cfg_ready_o = 1'b1;

  assign ld3 = !v3_q || out_ready_i;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign ld0 = !v0_q || ld1;
  assign in_ready_o = ld0;
  assign in_xfer = in_valid_i && ld0;

  assign lim_pos = $signed({2'b00, term_limit_q});
  assign lim_neg = -lim_pos;

  always_comb begin
    err_d  = $signed({setpoint_i[15], setpoint_i}) - $signed({measured_i[15], measured_i});
    diff_d = $signed({err_d[16], err_d}) - $signed({prev_err_q[16], prev_err_q});

    p_prod_d = err_q * prop_gain_q;
    i_prod_d = err_q * integ_gain_q;
    // times 100 = 64 + 32 + 4
    diff_ext = $signed({{7{diff_q[17]}}, diff_q});
    d100_d   = (diff_ext <<< 6) + (diff_ext <<< 5) + (diff_ext <<< 2);

    // an arithmetic shift by eight is the floor of a divide by 256
    p_term_d = pidc_pkg::clamp_s16($signed({{9{p_prod_q[32]}}, p_prod_q[32:8]}),
                                   lim_pos, lim_neg);
    i_sum    = $signed({{10{integ_q[15]}}, integ_q})
             + $signed({i_prod_q[32], i_prod_q[32:8]});
    i_term_d = pidc_pkg::clamp_s16($signed({{8{i_sum[25]}}, i_sum}),
                                   $signed({integ_high_q[15], integ_high_q}),
                                   $signed({integ_low_q[15], integ_low_q}));
    d_prod_d = d100_q * deriv_gain_q;

    d_term = pidc_pkg::clamp_s16($signed({d_prod_q[40], d_prod_q[40:8]}),
                                 lim_pos, lim_neg);
    sum    = $signed({{2{p_term_q[15]}}, p_term_q}) + $signed({{2{i_term_q[15]}}, i_term_q})
           + $signed({{2{d_term[15]}}, d_term});
    cmd_d  = pidc_pkg::clamp_s16($signed({{16{sum[17]}}, sum}),
                                 $signed({out_high_q[15], out_high_q}),
                                 $signed({out_low_q[15], out_low_q}));
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      deriv_gain_q <= '0;
      term_limit_q <= 15'h7fff;
      integ_high_q <= 16'sh7fff;
      integ_low_q  <= -16'sh8000;
      out_high_q   <= 16'sh7fff;
      out_low_q    <= -16'sh8000;
    end else if (cfg_valid_i) begin
      unique case (pidc_pkg::cfg_idx_e'(cfg_index_i))
        pidc_pkg::CfgPropGain:  prop_gain_q  <= $signed(cfg_data_i);
        pidc_pkg::CfgIntegGain: integ_gain_q <= $signed(cfg_data_i);
        pidc_pkg::CfgDerivGain: deriv_gain_q <= $signed(cfg_data_i);
        pidc_pkg::CfgTermLimit: term_limit_q <= cfg_data_i[14:0];
        pidc_pkg::CfgIntegHigh: integ_high_q <= $signed(cfg_data_i);
        pidc_pkg::CfgIntegLow:  integ_low_q  <= $signed(cfg_data_i);
        pidc_pkg::CfgOutHigh:   out_high_q   <= $signed(cfg_data_i);
        pidc_pkg::CfgOutLow:    out_low_q    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // valid bits and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q       <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      prev_err_q <= '0;
      integ_q    <= '0;
    end else begin
      if (ld0) v0_q <= in_valid_i;
      if (ld1) v1_q <= v0_q;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (in_xfer) prev_err_q <= err_d;
      // store the clamped integral back as the item leaves the product stage
      if (v1_q && ld2) integ_q <= i_term_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
    if (v0_q && ld1) begin
      p_prod_q <= p_prod_d;
      i_prod_q <= i_prod_d;
      d100_q   <= d100_d;
    end
    if (v1_q && ld2) begin
      p_term_q <= p_term_d;
      i_term_q <= i_term_d;
      d_prod_q <= d_prod_d;
    end
    if (v2_q && ld3) begin
      command_q <= cmd_d;
    end
  end

  assign out_valid_o = v3_q;
  assign command_o   = command_q;

  // assertions
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v0_q)
    else $error("accepted sample did not enter the error stage");

  a_integ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v1_q && ld2) |=> $stable(integ_q))
    else $error("integral changed without a sample passing");

  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && ld2 && (integ_low_q <= integ_high_q)
    |=> (integ_q >= $past(integ_low_q)) && (integ_q <= $past(integ_high_q)))
    else $error("stored integral outside its limits");

  a_p_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && ld2 |=> ($signed({p_term_q[15], p_term_q}) <= $past(lim_pos))
                 && ($signed({p_term_q[15], p_term_q}) >= $past(lim_neg)))
    else $error("proportional term exceeds term limit");

endmodule
`default_nettype wire

// ===== tb/pid_controller_clamped_terms_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller with clamped terms: testbench
// Drives setpoint/measured samples through bursts and gaps, stalls the
// command channel on a pattern of its own and checks every command against
// a predictor of the P, I and D terms, clamps and the stored integral.
// ----------------------------------------------------------------------------
module pid_controller_clamped_terms_top_tb;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseSamples = 200;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxReports   = 100;

  typedef enum int unsigned {
    RxFree,
    RxCoin,
    RxSparse,
    RxPeriodic
  } rx_mode_e;

  class pid_scoreboard;
    logic signed [pidc_pkg::DataW-1:0] prop_k, integ_k, deriv_k;
    logic        [pidc_pkg::LimitW-1:0] term_lim;
    logic signed [pidc_pkg::DataW-1:0] integ_hi, integ_lo, cmd_hi, cmd_lo;
    logic signed [pidc_pkg::DataW:0]   last_error;
    logic signed [pidc_pkg::DataW-1:0] integ_acc;
    logic signed [pidc_pkg::DataW-1:0] cmd_queue[$];
    int unsigned samples, commands, mismatches;

    function new();
      prop_k     = '0;
      integ_k    = '0;
      deriv_k    = '0;
      term_lim   = '1;
      integ_hi   = 16'sh7FFF;
      integ_lo   = 16'sh8000;
      cmd_hi     = 16'sh7FFF;
      cmd_lo     = 16'sh8000;
      last_error = '0;
      integ_acc  = '0;
      samples    = 0;
      commands   = 0;
      mismatches = 0;
    endfunction

    function void write_reg(pidc_pkg::cfg_idx_e idx, logic [pidc_pkg::DataW-1:0] data);
      case (idx)
        pidc_pkg::CfgPropGain:  prop_k   = data;
        pidc_pkg::CfgIntegGain: integ_k  = data;
        pidc_pkg::CfgDerivGain: deriv_k  = data;
        pidc_pkg::CfgTermLimit: term_lim = data[pidc_pkg::LimitW-1:0];
        pidc_pkg::CfgIntegHigh: integ_hi = data;
        pidc_pkg::CfgIntegLow:  integ_lo = data;
        pidc_pkg::CfgOutHigh:   cmd_hi   = data;
        pidc_pkg::CfgOutLow:    cmd_lo   = data;
        default: ;
      endcase
    endfunction

    // upper bound is tested first, so with crossed limits a value above hi gives hi, any other gives lo
    function longint sat(longint v, longint hi, longint lo);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void note_sample(logic signed [pidc_pkg::DataW-1:0] sp,
                              logic signed [pidc_pkg::DataW-1:0] ms);
      longint err, lim, p, i, d, total;
      err = longint'(sp) - longint'(ms);
      lim = longint'(term_lim);
      // arithmetic shift of the exact product gives the floor of x / 256
      p = sat((err * longint'(prop_k)) >>> 8, lim, -lim);
      i = sat(longint'(integ_acc) + ((err * longint'(integ_k)) >>> 8),
              longint'(integ_hi), longint'(integ_lo));
      d = sat(((err - longint'(last_error)) * 100 * longint'(deriv_k)) >>> 8, lim, -lim);
      last_error = err[pidc_pkg::DataW:0];
      integ_acc  = i[pidc_pkg::DataW-1:0];
      total = sat(p + i + d, longint'(cmd_hi), longint'(cmd_lo));
      cmd_queue.push_back(total[pidc_pkg::DataW-1:0]);
      samples++;
    endfunction

    function void check_command(logic signed [pidc_pkg::DataW-1:0] got);
      logic signed [pidc_pkg::DataW-1:0] want;
      if (cmd_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: command %0d arrived with no sample waiting", $time, got);
        return;
      end
      want = cmd_queue.pop_front();
      commands++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: command mismatch: expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic signed [pidc_pkg::DataW-1:0] setpoint_i;
  logic signed [pidc_pkg::DataW-1:0] measured_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic signed [pidc_pkg::DataW-1:0] command_o;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [pidc_pkg::CfgIdxW-1:0]      cfg_index_i;
  logic [pidc_pkg::DataW-1:0]        cfg_data_i;

  pid_scoreboard sb;
  int unsigned   burst_left = 0;
  int unsigned   settings   = 0;
  int unsigned   cycle_count = 0;
  rx_mode_e      rx_mode    = RxFree;
  int unsigned   rx_left    = 0;
  int unsigned   rx_period  = 2;

  pid_controller_clamped_terms_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .setpoint_i  (setpoint_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .command_o   (command_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Command side: check each transfer, then pick the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_command(command_o);
    if (rx_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      rx_left   = $urandom_range(4, 80);
      rx_period = $urandom_range(2, 6);
    end
    rx_left--;
    case (rx_mode)
      RxFree:   out_ready_i <= 1'b1;
      RxCoin:   out_ready_i <= 1'($urandom_range(0, 1));
      RxSparse: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:  out_ready_i <= ((rx_left % rx_period) == 0);
    endcase
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d commands still due", cycle_count,
             sb.cmd_queue.size());
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_sample(input logic signed [pidc_pkg::DataW-1:0] sp,
                             input logic signed [pidc_pkg::DataW-1:0] ms);
    int unsigned gap;
    int unsigned pick;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      pick = $urandom_range(0, 19);
      if (pick < 14)      burst_left = $urandom_range(1, 8);
      else if (pick < 19) burst_left = $urandom_range(9, 40);
      else                burst_left = $urandom_range(100, 300);
    end
    in_valid_i <= 1'b1;
    setpoint_i <= sp;
    measured_i <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(sp, ms);
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  // drop valid if a burst is still open
  task automatic hold_inputs();
    if (burst_left != 0) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic wait_drained();
    while (sb.cmd_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input pidc_pkg::cfg_idx_e idx,
                           input logic [pidc_pkg::DataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [pidc_pkg::DataW-1:0] kp,
                              input logic [pidc_pkg::DataW-1:0] ki,
                              input logic [pidc_pkg::DataW-1:0] kd,
                              input logic [pidc_pkg::DataW-1:0] lim,
                              input logic [pidc_pkg::DataW-1:0] ihi,
                              input logic [pidc_pkg::DataW-1:0] ilo,
                              input logic [pidc_pkg::DataW-1:0] ohi,
                              input logic [pidc_pkg::DataW-1:0] olo);
    hold_inputs();
    wait_drained();
    cfg_write(pidc_pkg::CfgPropGain, kp);
    cfg_write(pidc_pkg::CfgIntegGain, ki);
    cfg_write(pidc_pkg::CfgDerivGain, kd);
    cfg_write(pidc_pkg::CfgTermLimit, lim);
    cfg_write(pidc_pkg::CfgIntegHigh, ihi);
    cfg_write(pidc_pkg::CfgIntegLow, ilo);
    cfg_write(pidc_pkg::CfgOutHigh, ohi);
    cfg_write(pidc_pkg::CfgOutLow, olo);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  function automatic logic [pidc_pkg::DataW-1:0] pick_gain();
    logic [pidc_pkg::DataW-1:0] g;
    case ($urandom_range(0, 7))
      0:       g = 16'h8000;
      1:       g = 16'h7FFF;
      2:       g = 16'h0000;
      3:       g = 16'h0100;
      4, 5: begin
        g = 16'($urandom_range(0, 1536));
        g = g - 16'd768;
      end
      default: g = 16'($urandom);
    endcase
    return g;
  endfunction

  // bit 15 is not part of the limit and is driven at random
  function automatic logic [pidc_pkg::DataW-1:0] pick_term_limit();
    logic [pidc_pkg::DataW-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = 16'h0000;
      1:       v = 16'h7FFF;
      2:       v = 16'($urandom_range(0, 255));
      default: v = 16'($urandom_range(0, 32767));
    endcase
    v[pidc_pkg::DataW-1] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  task automatic pick_window(output logic [pidc_pkg::DataW-1:0] hi,
                             output logic [pidc_pkg::DataW-1:0] lo);
    case ($urandom_range(0, 6))
      0: begin
        hi = 16'h7FFF;
        lo = 16'h8000;
      end
      1: begin
        // crossed window
        hi = 16'($urandom_range(0, 3000));
        hi = -hi;
        lo = 16'($urandom_range(0, 3000));
      end
      2: begin
        hi = 16'($urandom);
        lo = 16'($urandom);
      end
      default: begin
        hi = 16'($urandom_range(0, 20000));
        lo = 16'($urandom_range(0, 20000));
        lo = -lo;
      end
    endcase
  endtask

  task automatic pick_sample(output logic signed [pidc_pkg::DataW-1:0] sp,
                             output logic signed [pidc_pkg::DataW-1:0] ms);
    logic [31:0]                raw;
    logic [pidc_pkg::DataW-1:0] offs;
    int unsigned                kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // tracking loop: measurement near a moderate setpoint
      raw  = $urandom_range(0, 4000);
      sp   = raw[pidc_pkg::DataW-1:0] - 16'd2000;
      offs = 16'($urandom_range(0, 1000));
      ms   = sp + offs - 16'd500;
    end else if (kind < 9) begin
      raw = $urandom;
      sp  = raw[pidc_pkg::DataW-1:0];
      ms  = raw[2*pidc_pkg::DataW-1:pidc_pkg::DataW];
    end else begin
      case ($urandom_range(0, 4))
        0:       sp = 16'h8000;
        1:       sp = 16'h7FFF;
        2:       sp = 16'h0000;
        3:       sp = 16'hFFFF;
        default: sp = 16'h0001;
      endcase
      case ($urandom_range(0, 4))
        0:       ms = 16'h7FFF;
        1:       ms = 16'h8000;
        2:       ms = 16'h0000;
        3:       ms = 16'h0001;
        default: ms = 16'hFFFF;
      endcase
    end
  endtask

  initial begin : stimulus
    logic [pidc_pkg::DataW-1:0]        ihi, ilo, ohi, olo;
    logic signed [pidc_pkg::DataW-1:0] sp, ms;
    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    setpoint_i  <= '0;
    measured_i  <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= pidc_pkg::CfgPropGain;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first sample after reset sees a zero previous error in the derivative
    program_regs(16'h0100, 16'h0100, 16'h0001, 16'h7FFF,
                 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_sample(16'sd1000, 16'sd0);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd0);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sd1, -16'sd1);
    send_sample(16'sh8000, 16'sh8000);

    // zero term limit forces P and D to nothing
    program_regs(16'h7FFF, 16'h8000, 16'h8000, 16'h0000,
                 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sd100, -16'sd100);
    send_sample(16'sd0, 16'sd0);

    // crossed integral and output windows
    program_regs(16'h0100, 16'h0100, 16'h0000, 16'h7FFF,
                 16'hFF9C, 16'h0064, 16'hFFCE, 16'h0032);
    send_sample(16'sd1000, 16'sd0);
    send_sample(-16'sd1000, 16'sd0);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd50, 16'sd0);
    send_sample(-16'sd50, 16'sd0);

    // extreme gains, tight windows, limit written with its unused top bit set
    program_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                 16'h0FA0, 16'hF060, 16'h2000, 16'hE000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sd12345, -16'sd12345);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd0, 16'sd0);

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      pick_window(ihi, ilo);
      pick_window(ohi, olo);
      program_regs(pick_gain(), pick_gain(), pick_gain(), pick_term_limit(),
                   ihi, ilo, ohi, olo);
      for (int unsigned n = 0; n < PhaseSamples; n++) begin
        // now and then hold the sender until every command is back
        if ((phase % 3 == 0) && (n == PhaseSamples / 2)) begin
          hold_inputs();
          wait_drained();
        end
        pick_sample(sp, ms);
        send_sample(sp, ms);
      end
    end

    hold_inputs();
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Summary: %0d samples over %0d register settings, %0d commands checked",
             sb.samples, settings, sb.commands);
    $display("Summary: %0d mismatches, %0d cycles", sb.mismatches, cycle_count);
    if (sb.mismatches == 0 && sb.cmd_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (sb.cmd_queue.size() != 0)
        $display("%0t: %0d expected commands never arrived", $time, sb.cmd_queue.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== pid_controller_clamped_terms_top.f =====
hw/rtl/pidc_pkg.sv
hw/rtl/pid_controller_clamped_terms_top.sv
tb/pid_controller_clamped_terms_top_tb.sv
